// ===== rtl/pel_pkg.sv =====
// ----------------------------------------------------------------------------
// pel_pkg: shared types and constants of the process event log
// Record depth, index widths, operation codes and the query token that
// travels along the row of record cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pel_pkg;

	// Record depth and derived widths
	localparam int ENTRIES = 64;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Field widths of a beat
	localparam int OP_W   = 2;
	localparam int PID_W  = 15;
	localparam int TS_W   = 31;
	localparam int TIME_W = 32;
	localparam int SLOT_W = 6;
	localparam int ECNT_W = 7;

	// Operation codes; the fourth code changes no record and finds nothing
	localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
	localparam logic [OP_W-1:0] OP_TERM   = 2'd1;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

	// Time value meaning "none"
	localparam logic [TIME_W-1:0] NONE_TIME = '1;

	// Query token handed from cell to cell
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [PID_W-1:0]  pid;
		logic [TS_W-1:0]   ts;
		logic              found;
		logic [IDX_W-1:0]  slot;
		logic [TIME_W-1:0] ct;
		logic [TIME_W-1:0] tt;
	} pel_tok_t;

endpackage

`default_nettype wire

// ===== rtl/pel_cell.sv =====
// ----------------------------------------------------------------------------
// pel_cell: one record slot of the process event log
// Holds pid, creation and termination time of one slot. A query token
// passes through, registered, whenever the row advances; the first live cell with a matching pid claims
// it, and a create token writes the cell whose index it carries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pel_cell
	import pel_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [IDX_W-1:0] index,
	input  wire logic [CNT_W-1:0] count,
	input  wire logic             vld_i,
	input  wire pel_tok_t         tok_i,
	output logic                  vld_o,
	output pel_tok_t              tok_o
);

	logic [PID_W-1:0]  pid_q;
	logic [TS_W-1:0]   start_q;
	logic [TIME_W-1:0] end_q;
	logic              vld_q;
	pel_tok_t          tok_q;
	pel_tok_t          tok_n;
	logic              live;
	logic              search;
	logic              hit;
	logic              wr;

	// Match the passing token against this slot
	always_comb begin
		live   = CNT_W'(index) < count;
		search = (tok_i.op == OP_TERM) || (tok_i.op == OP_LOOKUP);
		hit    = vld_i && !tok_i.found && search && live && (pid_q == tok_i.pid);
		wr     = vld_i && (tok_i.op == OP_CREATE) && (tok_i.slot == index);
		tok_n  = tok_i;
		if (hit) begin
			tok_n.found = 1'b1;
			tok_n.slot  = index;
			tok_n.ct    = {1'b0, start_q};
			tok_n.tt    = (tok_i.op == OP_TERM) ? {1'b0, tok_i.ts} : end_q;
		end
	end

	// Advance the token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_i;
		end
	end

	// Advance the token payload and update the record
	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_n;
			if (wr) begin
				pid_q   <= tok_i.pid;
				start_q <= tok_i.ts;
				end_q   <= NONE_TIME;
			end else if (hit && (tok_i.op == OP_TERM)) begin
				end_q <= {1'b0, tok_i.ts};
			end
		end
	end

	assign vld_o = vld_q;
	assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/process_event_log_ring.sv =====
// Flow: the query token walks the row of record cells, one cell a cycle
// while the output is not stalled, and then lands in the result register.
// A new beat is taken only once the token has left the row, even while
// the result still waits.
// Reset: arst_n clears write slot, full flag and all valid bits at once.
// ----------------------------------------------------------------------------
// process_event_log_ring: circular process record log with pid search
// Create beats write the record at the write slot and advance it with wrap;
// terminate and lookup beats search from slot 0 upward for the first pid
// match among the live records.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module process_event_log_ring
	import pel_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // pid[14:0], timestamp[45:15], zero pad
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // slot[5:0], creation_time[37:6],
	                                    // termination_time[69:38],
	                                    // entry_count[76:70], zero pad
	output logic [0:0]       m_tuser    // found[0]
);

	logic              busy_q;
	logic [IDX_W-1:0]  wslot_q;
	logic              wrapped_q;
	logic [CNT_W-1:0]  count;
	logic              acc;
	logic              adv;
	logic              last_vld;
	logic              m_tvalid_q;
	pel_tok_t          res_q;
	logic [CNT_W-1:0]  rcnt_q;
	pel_tok_t          inj;
	logic [ENTRIES:0]  vld_c;
	pel_tok_t          tok_c [ENTRIES+1];
	logic [IDX_W+SLOT_W-1:0] slot_ext;
	logic [CNT_W+ECNT_W-1:0] cnt_ext;

	assign count    = wrapped_q ? CNT_W'(ENTRIES) : CNT_W'(wslot_q);
	assign s_tready = !busy_q;
	assign acc      = s_tvalid && s_tready;
	assign last_vld = vld_c[ENTRIES];
	assign adv      = !(last_vld && m_tvalid_q && !m_tready);

	// Build the entry token; a create reports its write slot right away
	always_comb begin
		inj.op    = s_tuser;
		inj.pid   = s_tdata[14:0];
		inj.ts    = s_tdata[45:15];
		inj.found = 1'b0;
		inj.slot  = '0;
		inj.ct    = NONE_TIME;
		inj.tt    = NONE_TIME;
		if (s_tuser == OP_CREATE) begin
			inj.found = 1'b1;
			inj.slot  = wslot_q;
			inj.ct    = {1'b0, s_tdata[45:15]};
		end
	end

	assign vld_c[0] = acc;
	assign tok_c[0] = inj;

	// Row of record cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		pel_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.index  (IDX_W'(i)),
			.count  (count),
			.vld_i  (vld_c[i]),
			.tok_i  (tok_c[i]),
			.vld_o  (vld_c[i+1]),
			.tok_o  (tok_c[i+1])
		);
	end

	// Track busy, write slot and full flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			wslot_q   <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (acc) begin
				busy_q <= 1'b1;
			end else if (last_vld && adv) begin
				busy_q <= 1'b0;
			end
			if (acc && (s_tuser == OP_CREATE)) begin
				if (wslot_q == IDX_W'(ENTRIES - 1)) begin
					wslot_q   <= '0;
					wrapped_q <= 1'b1;
				end else begin
					wslot_q <= wslot_q + 1'b1;
				end
			end
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (last_vld && adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_vld && adv) begin
			res_q  <= tok_c[ENTRIES];
			rcnt_q <= count;
		end
	end

	// Pack the result beat
	assign slot_ext = {{SLOT_W{1'b0}}, res_q.slot};
	assign cnt_ext  = {{ECNT_W{1'b0}}, rcnt_q};
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = res_q.found;
	assign m_tdata  = {3'b000, cnt_ext[ECNT_W-1:0], res_q.tt, res_q.ct,
		slot_ext[SLOT_W-1:0]};

	// At most one token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_c[ENTRIES:1]) <= 1)
		else $error("more than one token in the cell row");

	// Input is taken only with an empty row
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (vld_c[ENTRIES:1] == '0))
		else $error("input ready while a token is in flight");

	// A token leaving the row lands in the result register
	a_exit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(last_vld && adv) |=> m_tvalid_q)
		else $error("result lost at the end of the row");

	// A create below the last slot advances the write slot by one
	a_wslot_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (s_tuser == OP_CREATE) && (wslot_q != IDX_W'(ENTRIES - 1)))
		|=> (wslot_q == $past(wslot_q) + 1'b1))
		else $error("write slot did not advance");

endmodule

`default_nettype wire

// ===== verif/tb_process_event_log_ring.sv =====
// ----------------------------------------------------------------------------
// tb_process_event_log_ring: self-checking bench for the process event log
// Streams create, terminate, lookup and unused-code beats into the log under
// bursty input and a stalling output. A local copy of the record ring predicts
// every result beat, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_process_event_log_ring;
	import pel_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
	localparam int              CYCLE_LIMIT = 1000000;
	localparam int              RANDOM_EVENTS = 1000;
	localparam int              PID_POOL    = 12;

	// One input beat plus a flag that holds it until the log has drained
	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [PID_W-1:0] pid;
		logic [TS_W-1:0]  ts;
		logic             drain_first;
	} log_event_t;

	// One result beat
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] ct;
		logic [TIME_W-1:0] tt;
		logic [ECNT_W-1:0] cnt;
	} log_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // pid[14:0], timestamp[45:15], zero pad
	logic [1:0]  s_tuser = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;        // slot[5:0], creation_time[37:6],
	                             // termination_time[69:38], entry_count[76:70]
	logic [0:0]  m_tuser;        // found[0]

	process_event_log_ring DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Local record ring
	logic [PID_W-1:0]  rec_pid   [ENTRIES];
	logic [TS_W-1:0]   rec_start [ENTRIES];
	logic [TIME_W-1:0] rec_end   [ENTRIES];
	int                wr_slot = 0;
	bit                log_full = 1'b0;

	log_event_t pending_events[$];
	log_reply_t expected_records[$];
	log_event_t on_bus = '0;

	int events_taken = 0;
	int replies_seen = 0;
	int errors = 0;
	int cycle_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_left = 0;
	int n_create = 0, n_term = 0, n_term_hit = 0, n_lookup = 0, n_lookup_hit = 0;
	int n_unused = 0, n_wraps = 0;
	logic [PID_W-1:0] pid_pool[PID_POOL];

	// Clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one accepted beat to the local ring and return its result
	function automatic log_reply_t log_apply(input logic [OP_W-1:0] op,
		input logic [PID_W-1:0] pid, input logic [TS_W-1:0] ts);
		log_reply_t r;
		int hit;
		int live;
		r.found = 1'b0;
		r.slot  = '0;
		r.ct    = NONE_TIME;
		r.tt    = NONE_TIME;
		hit     = -1;
		live    = log_full ? ENTRIES : wr_slot;
		if (op == OP_CREATE) begin
			n_create++;
			rec_pid[wr_slot]   = pid;
			rec_start[wr_slot] = ts;
			rec_end[wr_slot]   = NONE_TIME;
			r.found = 1'b1;
			r.slot  = SLOT_W'(wr_slot);
			r.ct    = {1'b0, ts};
			if (wr_slot == ENTRIES - 1) begin
				wr_slot  = 0;
				log_full = 1'b1;
				n_wraps++;
			end else begin
				wr_slot++;
			end
		end else if (op == OP_TERM || op == OP_LOOKUP) begin
			// first live match from slot 0 upward
			for (int i = 0; i < live; i++)
				if (hit < 0 && rec_pid[i] == pid)
					hit = i;
			if (op == OP_TERM) n_term++;
			else n_lookup++;
			if (hit >= 0) begin
				if (op == OP_TERM) begin
					rec_end[hit] = {1'b0, ts};
					n_term_hit++;
				end else begin
					n_lookup_hit++;
				end
				r.found = 1'b1;
				r.slot  = SLOT_W'(hit);
				r.ct    = {1'b0, rec_start[hit]};
				r.tt    = rec_end[hit];
			end
		end else begin
			n_unused++;
		end
		r.cnt = ECNT_W'(log_full ? ENTRIES : wr_slot);
		return r;
	endfunction

	function automatic void add_event(input logic [OP_W-1:0] op, input int pid,
		input logic [TS_W-1:0] ts, input bit drain);
		log_event_t e;
		e.op          = op;
		e.pid         = PID_W'(pid);
		e.ts          = ts;
		e.drain_first = drain;
		pending_events.push_back(e);
	endfunction

	function automatic void check_field(input string name,
		input logic signed [31:0] want, input logic signed [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Driver: bursts of beats with random gaps between them
	always @(posedge clk or negedge arst_n) begin
		log_event_t nxt;
		logic send;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			send = 1'b0;
			nxt  = on_bus;
			if (s_tvalid && s_tready) begin
				expected_records.push_back(log_apply(on_bus.op, on_bus.pid, on_bus.ts));
				events_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_events.size() > 0 &&
					!(pending_events[0].drain_first && events_taken != replies_seen)) begin
					nxt  = pending_events.pop_front();
					send = 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 12);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
					end
				end
				on_bus = nxt;
				s_tvalid <= send;
				s_tdata  <= {2'b00, nxt.ts, nxt.pid};
				s_tuser  <= nxt.op;
			end
		end
	end

	// Monitor: check result beats and stall the output side
	always @(posedge clk or negedge arst_n) begin
		log_reply_t want;
		logic rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				replies_seen <= replies_seen + 1;
				if (expected_records.size() == 0) begin
					$display("%0t: result beat with none expected, got %h / %h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = expected_records.pop_front();
					check_field("found", 32'(want.found), 32'(m_tuser[0]));
					check_field("slot", 32'(want.slot), 32'(m_tdata[5:0]));
					check_field("creation_time", want.ct, m_tdata[37:6]);
					check_field("termination_time", want.tt, m_tdata[69:38]);
					check_field("entry_count", 32'(want.cnt), 32'(m_tdata[76:70]));
				end
			end
			// cycle through free, randomly choppy and long-stall phases
			rdy = 1'b1;
			if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else begin
				case ((cycle_count / 4000) % 3)
					1: rdy = ($urandom_range(0, 3) != 0);
					2: begin
						if ($urandom_range(0, 9) == 0) begin
							stall_left = $urandom_range(1, 40);
							rdy = 1'b0;
						end
					end
					default: rdy = 1'b1;
				endcase
			end
			m_tready <= rdy;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, events_taken - replies_seen);
			$display("tb_process_event_log_ring: errors");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		logic [OP_W-1:0] op;
		int pick;
		int pid;

		// lookups, terminates and an unused code on an empty log
		add_event(OP_LOOKUP, 0, 31'd0, 1'b0);
		add_event(OP_TERM, 5, 31'd100, 1'b0);
		add_event(OP_UNUSED, 32767, 31'h7FFFFFFF, 1'b0);
		// field extremes and alternating bit patterns
		add_event(OP_CREATE, 0, 31'd0, 1'b0);
		add_event(OP_CREATE, 32767, 31'h7FFFFFFF, 1'b0);
		add_event(OP_CREATE, 'h5555, 31'h2AAAAAAA, 1'b0);
		add_event(OP_CREATE, 'h2AAA, 31'h55555555, 1'b0);
		add_event(OP_LOOKUP, 32767, 31'd0, 1'b0);
		add_event(OP_TERM, 32767, 31'h7FFFFFFF, 1'b0);
		add_event(OP_LOOKUP, 32767, 31'h1234, 1'b0);
		add_event(OP_LOOKUP, 0, 31'd0, 1'b0);
		// repeated pid resolves to the lowest slot
		add_event(OP_CREATE, 0, 31'd1234, 1'b0);
		add_event(OP_LOOKUP, 0, 31'd0, 1'b0);
		add_event(OP_TERM, 0, 31'd99, 1'b0);
		add_event(OP_LOOKUP, 0, 31'd0, 1'b0);
		// misses, the unused code and a lookup that hits
		add_event(OP_LOOKUP, 12345, 31'd0, 1'b0);
		add_event(OP_TERM, 12345, 31'd77, 1'b0);
		add_event(OP_UNUSED, 0, 31'd0, 1'b0);
		add_event(OP_LOOKUP, 'h5555, 31'h7FFFFFFF, 1'b0);

		// random traffic over a small pid pool so that searches hit
		pid_pool[0] = '0;
		pid_pool[1] = '1;
		for (int i = 2; i < PID_POOL; i++)
			pid_pool[i] = PID_W'($urandom_range(0, 32767));
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) op = OP_CREATE;
			else if (pick < 65) op = OP_TERM;
			else if (pick < 93) op = OP_LOOKUP;
			else op = OP_UNUSED;
			if ($urandom_range(0, 4) == 0) pid = $urandom_range(0, 32767);
			else pid = int'(pid_pool[$urandom_range(0, PID_POOL - 1)]);
			add_event(op, pid, TS_W'($urandom), (i == 0) || (i == RANDOM_EVENTS / 2));
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the input to drain and every result to arrive
		@(negedge clk);
		while (pending_events.size() > 0 || s_tvalid || events_taken != replies_seen)
			@(negedge clk);
		repeat (ENTRIES + 8) @(posedge clk);

		$display("%0d beats: %0d creates (%0d wraps), %0d terminates (%0d hit),",
			events_taken, n_create, n_wraps, n_term, n_term_hit);
		$display("%0d lookups (%0d hit), %0d unused codes; %0d results checked",
			n_lookup, n_lookup_hit, n_unused, replies_seen);
		if (expected_records.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_records.size());
			errors++;
		end
		if (errors == 0) begin
			$display("tb_process_event_log_ring: clean");
		end else begin
			$display("tb_process_event_log_ring: errors");
		end
		$finish;
	end

endmodule

`default_nettype wire
